[rtl/roulette_wheel_selector_assert.svh]
// assertion macros used by the roulette wheel selector rtl (rws_ctrl)
`ifndef ROULETTE_WHEEL_SELECTOR_ASSERT_SVH
`define ROULETTE_WHEEL_SELECTOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RWS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_pkg
// types, codes and constants of the roulette wheel selector
// ----------------------------------------------------------------------------
package rws_pkg;

    localparam int MaxEntriesDef  = 256;
    localparam int FitnessBitsDef = 16;

    localparam int FitPortBits = 16;
    localparam int TotalBits   = 24;
    localparam int IdxOutBits  = 8;

    localparam logic [TotalBits-1:0] TotalMax = '1;

    // command codes
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_DRAW   = 1'b1;

    // status codes
    localparam logic STS_OK    = 1'b0;
    localparam logic STS_EMPTY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAST,
        ST_MID,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [IdxOutBits-1:0] selected_index;
        logic                  status;
        logic [TotalBits-1:0]  total_fitness;
    } t_result;

endpackage

[rtl/rws_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_in_if / rws_out_if
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
interface rws_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        first;
    logic [15:0] fitness_value;
    logic [23:0] draw_value;

    modport source (output valid, command, first, fitness_value, draw_value, input ready);
    modport sink   (input valid, command, first, fitness_value, draw_value, output ready);
endinterface

interface rws_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  selected_index;
    logic        status;
    logic [23:0] total_fitness;

    modport source (output valid, selected_index, status, total_fitness, input ready);
    modport sink   (input valid, selected_index, status, total_fitness, output ready);
endinterface

[rtl/rws_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rws_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rws_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_ctrl
// append bookkeeping and binary search over the prefix-sum ram
// ----------------------------------------------------------------------------
`include "roulette_wheel_selector_assert.svh"

module rws_ctrl #(
    parameter int MAX_ENTRIES  = rws_pkg::MaxEntriesDef,
    parameter int FITNESS_BITS = rws_pkg::FitnessBitsDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command beat
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_command,
    input  logic                           i_first,
    input  logic [rws_pkg::FitPortBits-1:0] i_fitness_value,
    input  logic [rws_pkg::TotalBits-1:0]  i_draw_value,
    // result hand-off
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output rws_pkg::t_result               o_res,
    // prefix-sum ram
    output logic                           o_mem_we,
    output logic [$clog2(MAX_ENTRIES)-1:0] o_mem_waddr,
    output logic [rws_pkg::TotalBits-1:0]  o_mem_wdata,
    output logic                           o_mem_re,
    output logic [$clog2(MAX_ENTRIES)-1:0] o_mem_raddr,
    input  logic [rws_pkg::TotalBits-1:0]  i_mem_rdata
);
    import rws_pkg::*;

    localparam int IdxW = $clog2(MAX_ENTRIES);
    localparam int CntW = $clog2(MAX_ENTRIES + 1);
    localparam logic [FitPortBits-1:0] FitMask = (FITNESS_BITS >= FitPortBits) ?
        {FitPortBits{1'b1}} : FitPortBits'((64'd1 << FITNESS_BITS) - 64'd1);

    t_state              r_state, n_state;
    logic [CntW-1:0]     r_count, n_count;
    logic [TotalBits-1:0] r_total, n_total;
    logic [TotalBits-1:0] r_thr, n_thr;
    logic [IdxW-1:0]     r_lo, n_lo;
    logic [IdxW-1:0]     r_hi, n_hi;
    logic [IdxW-1:0]     r_mid, n_mid;
    logic [IdxW-1:0]     r_idx, n_idx;
    logic                r_status, n_status;

    logic                acc, acc_draw, acc_append, empty;
    logic [IdxW-1:0]     last_idx;
    logic                gt, hit_last, search_done;
    logic [IdxW-1:0]     cand_lo, cand_hi, next_mid, found_idx;
    logic [CntW-1:0]     base_count;
    logic [TotalBits-1:0] base_total;
    logic [TotalBits:0]  sum;
    logic [TotalBits-1:0] sat_total;
    logic                room;

    // shared decode and search step
    always_comb begin
        acc        = i_valid && o_ready;
        acc_draw   = acc && (i_command == CMD_DRAW);
        acc_append = acc && (i_command == CMD_APPEND);
        empty      = (r_count == '0) || (r_total == '0);
        last_idx   = IdxW'(r_count - CntW'(1));
        gt         = i_mem_rdata > r_thr;
        hit_last   = (r_state == ST_LAST) && !gt;
        if (r_state == ST_MID) begin
            cand_lo = gt ? r_lo : IdxW'(r_mid + IdxW'(1));
            cand_hi = gt ? r_mid : r_hi;
        end else begin
            cand_lo = r_lo;
            cand_hi = r_hi;
        end
        search_done = hit_last || (cand_lo == cand_hi);
        found_idx   = hit_last ? r_hi : cand_lo;
        next_mid    = IdxW'(cand_lo + ((cand_hi - cand_lo) >> 1));

        base_count = i_first ? '0 : r_count;
        base_total = i_first ? '0 : r_total;
        room       = base_count < CntW'(MAX_ENTRIES);
        sum        = {1'b0, base_total} + (TotalBits+1)'(i_fitness_value & FitMask);
        sat_total  = sum[TotalBits] ? TotalMax : sum[TotalBits-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_draw) begin
                    n_state = empty ? ST_DONE : ST_LAST;
                end
            end
            ST_LAST, ST_MID: begin
                n_state = search_done ? ST_DONE : ST_MID;
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready     = (r_state == ST_IDLE);
        o_res_valid = (r_state == ST_DONE);
        o_mem_we    = acc_append && room;
        o_mem_waddr = base_count[IdxW-1:0];
        o_mem_wdata = sat_total;
        o_mem_re    = 1'b0;
        o_mem_raddr = next_mid;
        unique case (r_state)
            ST_IDLE: begin
                o_mem_re    = acc_draw && !empty;
                o_mem_raddr = last_idx;
            end
            ST_LAST, ST_MID: begin
                o_mem_re = !search_done;
            end
            default: o_mem_re = 1'b0;
        endcase
    end

    assign o_res.selected_index = IdxOutBits'(r_idx);
    assign o_res.status         = r_status;
    assign o_res.total_fitness  = r_total;

    // datapath next values
    always_comb begin
        n_count  = r_count;
        n_total  = r_total;
        n_thr    = r_thr;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_idx    = r_idx;
        n_status = r_status;
        if (acc_append) begin
            n_count = base_count;
            n_total = base_total;
            if (room) begin
                n_count = CntW'(base_count + CntW'(1));
                n_total = sat_total;
            end
        end
        if (acc_draw) begin
            n_thr    = i_draw_value;
            n_lo     = '0;
            n_hi     = last_idx;
            n_mid    = last_idx;
            n_idx    = '0;
            n_status = empty ? STS_EMPTY : STS_OK;
        end
        if ((r_state == ST_LAST) || (r_state == ST_MID)) begin
            n_lo  = cand_lo;
            n_hi  = cand_hi;
            n_mid = next_mid;
            n_idx = found_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
        end
        r_thr    <= n_thr;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_idx    <= n_idx;
        r_status <= n_status;
    end

    `RWS_ASSERT_SAME(a_mid_in_range, i_clk, i_rst_n, r_state == ST_MID, r_mid < r_hi, "probe outside search window")
    `RWS_ASSERT_SAME(a_no_rw_clash, i_clk, i_rst_n, o_mem_we, !o_mem_re, "ram write and read in one cycle")
    `RWS_ASSERT_SAME(a_idx_loaded, i_clk, i_rst_n, (r_state == ST_DONE) && (r_status == STS_OK), CntW'(r_idx) < r_count, "selected entry not loaded")
    `RWS_ASSERT_SAME(a_err_cause, i_clk, i_rst_n, (r_state == ST_DONE) && (r_status == STS_EMPTY), (r_count == '0) || (r_total == '0), "error status on a loaded wheel")
    `RWS_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, (r_state == ST_DONE) && !i_res_ready, r_state == ST_DONE, "result dropped before hand-off")

endmodule

[rtl/roulette_wheel_selector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roulette_wheel_selector
// fitness-proportional selection over a prefix-sum table held in ram
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  i_in      in   command, first, fitness_value, draw_value
//  o_out     out  selected_index, status, total_fitness (one per draw)
//
//  an append writes the saturated running total at the next free entry, if
//  there is room. a draw on a loaded wheel reads the last entry, then does a
//  binary search with one ram read per search step. an empty or zero-total
//  draw reads no ram and returns an empty status. i_rst_n is synchronous; it
//  clears the entry count and the running total, the ram is left as it is.
//  the result sits in an output register, so appends keep flowing while it
//  waits; a draw finishing into a full register holds until the beat goes.
// ----------------------------------------------------------------------------
module roulette_wheel_selector #(
    parameter int MAX_ENTRIES  = rws_pkg::MaxEntriesDef,
    parameter int FITNESS_BITS = rws_pkg::FitnessBitsDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rws_in_if.sink    i_in,
    rws_out_if.source o_out
);
    import rws_pkg::*;

    localparam int IdxW = $clog2(MAX_ENTRIES);

    // ram port signals
    logic                 mem_we, mem_re;
    logic [IdxW-1:0]      mem_waddr, mem_raddr;
    logic [TotalBits-1:0] mem_wdata, mem_rdata;

    // result hand-off into the output register
    logic    res_valid, res_ready;
    t_result res;

    logic    r_out_valid;
    t_result r_out;

    // output slot is free when empty or being drained this cycle
    assign res_ready = !r_out_valid || o_out.ready;

    rws_ctrl #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .FITNESS_BITS (FITNESS_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in.valid),
        .o_ready         (i_in.ready),
        .i_command       (i_in.command),
        .i_first         (i_in.first),
        .i_fitness_value (i_in.fitness_value),
        .i_draw_value    (i_in.draw_value),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_res           (res),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata)
    );

    // prefix sums, one entry per loaded member; only loaded entries are read
    rws_ram #(
        .WIDTH (TotalBits),
        .DEPTH (MAX_ENTRIES)
    ) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.selected_index = r_out.selected_index;
    assign o_out.status         = r_out.status;
    assign o_out.total_fitness  = r_out.total_fitness;

endmodule
